// ===== rtl/core/dssm_pkg.sv =====
// shared types and constants for the drum step sequencer mixer
// no dependencies; imported by dssm_ctrl, dssm_datapath and the top level

package dssm_pkg;

    localparam int DEF_TRACKS       = 7;
    localparam int DEF_STEPS        = 64;
    localparam int DEF_SAMPLE_DEPTH = 16384;

    localparam int STEP_LEN_W = 20;
    localparam int PATTERN_W  = 64;
    localparam int LEN_W      = 15;
    localparam int TIME_W     = 32;
    localparam int WORD_W     = 16;
    localparam int INDEX_W    = 14;
    localparam int TRACK_W    = 3;
    localparam int MIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    // holds 7 tracks x 64 steps of full-scale words with headroom
    localparam int ACC_W      = 26;

    localparam logic [STEP_LEN_W-1:0] STEP_LEN_RESET = 20'd6000;

    localparam logic signed [ACC_W-1:0] MIX_MAX = 26'sd8388607;
    localparam logic signed [ACC_W-1:0] MIX_MIN = -26'sd8388608;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN0    = 3'd1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_REWIND = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]                command;
        logic [TRACK_W-1:0]        track;
        logic [INDEX_W-1:0]        word_index;
        logic signed [WORD_W-1:0]  word_value;
        logic                      last_word;
    } in_item_t;

    typedef struct packed {
        logic signed [MIX_W-1:0]   mixed_sample;
        logic [TIME_W-1:0]         time_position;
        logic                      clipped;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic do_write;
        logic rewind;
        logic run_init;
        logic run_step;
        logic finish;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic last_pair;
        logic pipe_idle;
    } sts_t;

endpackage

// ===== rtl/core/dssm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module dssm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/dssm_ctrl.sv =====
// command sequencer for the drum step sequencer mixer
// depends on dssm_pkg; drives dssm_datapath through ctl_t / sts_t

module dssm_ctrl
    import dssm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  sts_t       sts,
    output logic       busy,
    output ctl_t       ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.latch    = accept;
        ctl.do_write = (state_reg == S_LOAD);
        ctl.run_step = (state_reg == S_RUN);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_e'(command))
                        CMD_LOAD:   state_next = S_LOAD;
                        CMD_TICK:
                        begin
                            ctl.run_init = 1'b1;
                            state_next   = S_RUN;
                        end
                        CMD_REWIND: ctl.rewind = 1'b1;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_RUN:
            begin
                if (sts.last_pair)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last ram read to land in the accumulator
                if (sts.pipe_idle)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/dssm_datapath.sv =====
// datapath: configuration registers, sample ram, step walk, mix accumulator
// depends on dssm_pkg and dssm_ram

module dssm_datapath
    import dssm_pkg::*;
#(
    parameter int TRACKS       = DEF_TRACKS,
    parameter int STEPS        = DEF_STEPS,
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              item,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PATTERN_W-1:0]  cfg_data,
    output logic                  done,
    output out_item_t             result
);

    localparam int TRK_W   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W   = $clog2(SAMPLE_DEPTH);
    localparam int DEPTH   = TRACKS * SAMPLE_DEPTH;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int START_W = STEP_LEN_W + STEP_W;

    // configuration
    logic [STEP_LEN_W-1:0] step_len_reg;
    logic [PATTERN_W-1:0]  pattern_reg [TRACKS];
    logic [LEN_W-1:0]      len_reg [TRACKS];

    in_item_t              item_reg;
    logic [TIME_W-1:0]     time_reg;

    // walk over tracks and steps
    logic [TRK_W-1:0]      tr_reg;
    logic [STEP_W-1:0]     k_reg;
    logic [START_W-1:0]    start_reg;
    logic [ADDR_W-1:0]     base_reg;

    // read pipeline
    logic                  s1_valid_reg;
    logic [IDX_W-1:0]      s1_rel_reg;
    logic [ADDR_W-1:0]     s1_base_reg;
    logic                  rd_valid_reg;
    logic [WORD_W-1:0]     rd_data;
    logic signed [ACC_W-1:0] acc_reg;

    logic                  done_reg;
    out_item_t             res_reg;

    logic [TIME_W-1:0]     rel;
    logic                  hit;
    logic                  load_ok;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic                  sat_hi;
    logic                  sat_lo;

    assign rel = time_reg - TIME_W'(start_reg);
    assign hit = pattern_reg[tr_reg][k_reg] && (rel < TIME_W'(len_reg[tr_reg]));

    assign load_ok = ({1'b0, item_reg.track} < (TRACK_W + 1)'(TRACKS))
                  && ({3'b000, item_reg.word_index} < (INDEX_W + 3)'(SAMPLE_DEPTH));
    assign waddr   = ADDR_W'(item_reg.track * SAMPLE_DEPTH) + ADDR_W'(item_reg.word_index);
    assign raddr   = s1_base_reg + ADDR_W'(s1_rel_reg);

    assign sts.last_pair = (tr_reg == TRK_W'(TRACKS - 1)) && (k_reg == STEP_W'(STEPS - 1));
    assign sts.pipe_idle = !s1_valid_reg && !rd_valid_reg;

    assign sat_hi = (acc_reg > MIX_MAX);
    assign sat_lo = (acc_reg < MIX_MIN);

    dssm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ctl.do_write && load_ok),
        .waddr (waddr),
        .wdata (item_reg.word_value),
        .re    (s1_valid_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len_reg <= STEP_LEN_RESET;
            for (int i = 0; i < TRACKS; i++)
            begin
                pattern_reg[i] <= '0;
                len_reg[i]     <= '0;
            end
            time_reg     <= '0;
            s1_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_STEP_LENGTH)
                begin
                    step_len_reg <= cfg_data[STEP_LEN_W-1:0];
                end
                for (int i = 0; i < TRACKS; i++)
                begin
                    if (cfg_index == REG_PATTERN0 + CFG_IDX_W'(i))
                    begin
                        pattern_reg[i] <= cfg_data;
                    end
                end
            end

            if (ctl.do_write && load_ok && item_reg.last_word)
            begin
                for (int i = 0; i < TRACKS; i++)
                begin
                    if (item_reg.track == TRACK_W'(i))
                    begin
                        len_reg[i] <= LEN_W'(item_reg.word_index) + LEN_W'(1);
                    end
                end
            end

            if (ctl.rewind)
            begin
                time_reg <= '0;
            end
            else if (ctl.finish)
            begin
                time_reg <= time_reg + TIME_W'(1);
            end

            s1_valid_reg <= ctl.run_step && hit;
            rd_valid_reg <= s1_valid_reg;
            done_reg     <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= item;
        end

        if (ctl.run_init)
        begin
            tr_reg    <= '0;
            k_reg     <= '0;
            start_reg <= '0;
            base_reg  <= '0;
        end
        else if (ctl.run_step)
        begin
            if (k_reg == STEP_W'(STEPS - 1))
            begin
                k_reg     <= '0;
                start_reg <= '0;
                tr_reg    <= tr_reg + TRK_W'(1);
                base_reg  <= base_reg + ADDR_W'(SAMPLE_DEPTH);
            end
            else
            begin
                k_reg     <= k_reg + STEP_W'(1);
                start_reg <= start_reg + START_W'(step_len_reg);
            end
        end

        s1_rel_reg  <= rel[IDX_W-1:0];
        s1_base_reg <= base_reg;

        if (ctl.run_init)
        begin
            acc_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'($signed(rd_data));
        end

        if (ctl.finish)
        begin
            res_reg.time_position <= time_reg;
            res_reg.clipped       <= sat_hi || sat_lo;
            if (sat_hi)
            begin
                res_reg.mixed_sample <= MIX_MAX[MIX_W-1:0];
            end
            else if (sat_lo)
            begin
                res_reg.mixed_sample <= MIX_MIN[MIX_W-1:0];
            end
            else
            begin
                res_reg.mixed_sample <= acc_reg[MIX_W-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // a ram beat only follows a hit registered the cycle before
    a_rd_follows_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(s1_valid_reg))
        else $error("ram read data without a preceding hit");

    // the result is taken only once the read pipeline is empty
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (!s1_valid_reg && !rd_valid_reg))
        else $error("result taken with reads still in flight");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_time_advanced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (time_reg == res_reg.time_position + TIME_W'(1)))
        else $error("time counter not advanced past the delivered result");

endmodule

// ===== rtl/core/drum_step_sequencer_mixer_top.sv =====
// top level of the drum step sequencer mixer
// depends on dssm_pkg, dssm_ctrl, dssm_datapath, dssm_ram
//
//   channel   signals                                   direction
//   command   start, busy, item                         in  (taken when start && !busy)
//   result    done, result                              out (one cycle, no backpressure)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in  (written when valid && ready)
//
// a load passes through S_LOAD and a rewind clears the time without leaving idle; a tick walks all
// TRACKS*STEPS track and step pairs, one pair per cycle through the shared compare
// unit and the single ram read port, then waits in S_DRAIN while the read pipe drains.
// the result strobe rises the cycle the block goes idle again.
// reset clears lengths, patterns and time and sets the step length to 6000; sample ram is not cleared.
// the result side cannot stall; cfg_ready is always high.

module drum_step_sequencer_mixer_top
    import dssm_pkg::*;
#(
    parameter int TRACKS       = DEF_TRACKS,
    parameter int STEPS        = DEF_STEPS,
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  done,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PATTERN_W-1:0]  cfg_data
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    dssm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .sts     (sts),
        .busy    (busy),
        .ctl     (ctl)
    );

    dssm_datapath #(
        .TRACKS       (TRACKS),
        .STEPS        (STEPS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
